@@ sv/rapc_pkg.sv @@
// Package for the RESP array command parser: widths, character codes,
// phase and event encodings, and the record passed from front to back.
// No dependencies; every other file imports it.
package rapc_pkg;

    // Number field widths of the count and the bulk length lines.
    localparam int COUNT_BITS = 16;
    localparam int LEN_BITS   = 30;
    localparam int NUM_BITS   = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
    // Accumulator width for value * 10 + digit before the limit check.
    localparam int ACC_BITS   = NUM_BITS + 4;

    localparam int IDX_BITS   = 16;
    localparam int ALEN_BITS  = 30;

    localparam logic [ACC_BITS-1:0] COUNT_LIMIT = ACC_BITS'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [ACC_BITS-1:0] LEN_LIMIT   = ACC_BITS'((64'd1 << LEN_BITS) - 64'd1);

    // Result queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_STAR    = 3'd0,
        PH_COUNT   = 3'd1,
        PH_DOLLAR  = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TCR     = 3'd5,
        PH_TLF     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        NS_SKIP   = 2'd0,
        NS_DIGITS = 2'd1,
        NS_DONE   = 2'd3
    } t_nstage;

    typedef enum logic [2:0] {
        EV_BYTE = 3'd0,
        EV_END  = 3'd1,
        EV_NULL = 3'd2,
        EV_DONE = 3'd3,
        EV_ERR  = 3'd4
    } t_event;

    // All results caused by one input word. A second result, when present,
    // is always a command-complete event carrying idx1.
    typedef struct packed {
        logic                 two;
        t_event               ev0;
        logic [7:0]           byte0;
        logic [IDX_BITS-1:0]  idx0;
        logic [ALEN_BITS-1:0] len0;
        logic [IDX_BITS-1:0]  idx1;
    } t_rec;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_AW:0]   count;
    } t_qstat;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

@@ sv/rapc_front.sv @@
// Parser front end: tracks the RESP framing one word per cycle while i_accept
// is high and turns each accepted word into a record of zero, one or two results.
// Depends on rapc_pkg.
module rapc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    output logic                o_rec_valid,
    output rapc_pkg::t_rec      o_rec
);
    import rapc_pkg::*;

    t_phase                r_phase, n_phase;
    logic                  r_cr, n_cr;
    t_nstage               r_stage, n_stage;
    logic                  r_neg, n_neg;
    logic [NUM_BITS-1:0]   r_val, n_val;
    logic                  r_ovf, n_ovf;
    logic [COUNT_BITS-1:0] r_args, n_args;
    logic [IDX_BITS-1:0]   r_cur, n_cur;
    logic [LEN_BITS-1:0]   r_pay, n_pay;

    // Decode of the current word.
    logic                  d_err, d_fin, d_done0, d_byte, d_feed, d_clear;
    t_event                d_fin_ev;
    logic [ALEN_BITS-1:0]  d_fin_len;
    logic                  line_end, num_bad;

    // Number accumulator.
    t_nstage               f_stage;
    logic                  f_neg, f_ovf;
    logic [NUM_BITS-1:0]   f_val;
    logic [ACC_BITS-1:0]   acc, limit;
    logic                  f_digits;

    logic [IDX_BITS-1:0]   cur_inc;
    logic [COUNT_BITS-1:0] args_dec;

    assign cur_inc  = r_cur + IDX_BITS'(1);
    assign args_dec = r_args - COUNT_BITS'(1);
    assign line_end = (i_in_byte == CH_LF) && r_cr;
    assign num_bad  = r_neg && (r_val != '0);
    assign limit    = (r_phase == PH_COUNT) ? COUNT_LIMIT : LEN_LIMIT;
    assign acc      = ACC_BITS'({r_val, 3'b000}) + ACC_BITS'({r_val, 1'b0})
                    + ACC_BITS'(i_in_byte - CH_ZERO);

    // Atoi-style digit collection for one word.
    always_comb begin
        f_stage  = r_stage;
        f_neg    = r_neg;
        f_val    = r_val;
        f_ovf    = r_ovf;
        f_digits = 1'b0;
        if (r_stage == NS_SKIP) begin
            if (is_ws(i_in_byte)) begin
                f_stage = NS_SKIP;
            end else if ((i_in_byte == CH_PLUS) || (i_in_byte == CH_MINUS)) begin
                f_neg   = (i_in_byte == CH_MINUS);
                f_stage = NS_DIGITS;
            end else begin
                f_digits = 1'b1;
            end
        end else if (r_stage == NS_DIGITS) begin
            f_digits = 1'b1;
        end
        if (f_digits) begin
            if (!is_digit(i_in_byte)) begin
                f_stage = NS_DONE;
            end else begin
                f_stage = NS_DIGITS;
                if (!r_ovf) begin
                    if (acc > limit) begin
                        f_ovf = 1'b1;
                    end else begin
                        f_val = NUM_BITS'(acc);
                    end
                end
            end
        end
    end

    // Classification of the word in the current phase.
    always_comb begin
        d_err     = 1'b0;
        d_fin     = 1'b0;
        d_done0   = 1'b0;
        d_byte    = 1'b0;
        d_feed    = 1'b0;
        d_clear   = 1'b0;
        d_fin_ev  = EV_END;
        d_fin_len = '0;
        case (r_phase)
            PH_STAR: begin
                if (!is_ws(i_in_byte)) begin
                    d_err   = (i_in_byte != CH_STAR);
                    d_clear = (i_in_byte == CH_STAR);
                end
            end
            PH_COUNT: begin
                if (line_end) begin
                    d_err   = r_ovf || num_bad;
                    d_done0 = !(r_ovf || num_bad) && (r_val == '0);
                end else begin
                    d_feed = 1'b1;
                end
            end
            PH_LEN: begin
                if (line_end) begin
                    if (r_ovf) begin
                        d_err = 1'b1;
                    end else if (num_bad) begin
                        d_err    = (r_val != NUM_BITS'(1));
                        d_fin    = (r_val == NUM_BITS'(1));
                        d_fin_ev = EV_NULL;
                    end
                end else begin
                    d_feed = 1'b1;
                end
            end
            PH_DOLLAR: begin
                d_err   = (i_in_byte != CH_DOLLAR);
                d_clear = (i_in_byte == CH_DOLLAR);
            end
            PH_PAYLOAD: begin
                d_byte = 1'b1;
            end
            PH_TCR: begin
                d_err = (i_in_byte != CH_CR);
            end
            PH_TLF: begin
                d_err     = (i_in_byte != CH_LF);
                d_fin     = (i_in_byte == CH_LF);
                d_fin_len = ALEN_BITS'(r_val);
            end
            default: begin
                d_err = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_cr    = r_cr;
        n_stage = r_stage;
        n_neg   = r_neg;
        n_val   = r_val;
        n_ovf   = r_ovf;
        n_args  = r_args;
        n_cur   = r_cur;
        n_pay   = r_pay;
        case (r_phase)
            PH_STAR: begin
                if (d_clear) begin
                    n_phase = PH_COUNT;
                    n_cur   = '0;
                end
            end
            PH_COUNT: begin
                if (line_end) begin
                    n_cr = 1'b0;
                    if (d_done0) begin
                        n_phase = PH_STAR;
                    end else if (!d_err) begin
                        n_args  = COUNT_BITS'(r_val);
                        n_phase = PH_DOLLAR;
                    end
                end
            end
            PH_LEN: begin
                if (line_end) begin
                    n_cr = 1'b0;
                    if (!d_err && !d_fin) begin
                        n_pay   = LEN_BITS'(r_val);
                        n_phase = (r_val == '0) ? PH_TCR : PH_PAYLOAD;
                    end
                end
            end
            PH_DOLLAR: begin
                if (d_clear) begin
                    n_phase = PH_LEN;
                end
            end
            PH_PAYLOAD: begin
                n_pay = r_pay - LEN_BITS'(1);
                if (n_pay == '0) begin
                    n_phase = PH_TCR;
                end
            end
            PH_TCR: begin
                if (!d_err) begin
                    n_phase = PH_TLF;
                end
            end
            PH_TLF: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_STAR;
            end
        endcase
        if (d_feed) begin
            n_cr    = (i_in_byte == CH_CR);
            n_stage = f_stage;
            n_neg   = f_neg;
            n_val   = f_val;
            n_ovf   = f_ovf;
        end
        if (d_clear) begin
            n_cr    = 1'b0;
            n_stage = NS_SKIP;
            n_neg   = 1'b0;
            n_val   = '0;
            n_ovf   = 1'b0;
        end
        if (d_err) begin
            n_phase = PH_STAR;
        end
        if (d_fin) begin
            n_cur   = cur_inc;
            n_args  = args_dec;
            n_phase = (args_dec == '0) ? PH_STAR : PH_DOLLAR;
        end
    end

    // Result record.
    always_comb begin
        o_rec       = '0;
        o_rec_valid = i_accept && (d_err || d_fin || d_done0 || d_byte);
        o_rec.idx0  = r_cur;
        if (d_err) begin
            o_rec.ev0 = EV_ERR;
        end else if (d_done0) begin
            o_rec.ev0  = EV_DONE;
            o_rec.idx0 = '0;
        end else if (d_byte) begin
            o_rec.ev0   = EV_BYTE;
            o_rec.byte0 = i_in_byte;
        end else if (d_fin) begin
            o_rec.ev0  = d_fin_ev;
            o_rec.len0 = d_fin_len;
            o_rec.two  = (args_dec == '0);
            o_rec.idx1 = cur_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STAR;
            r_cr    <= 1'b0;
            r_stage <= NS_SKIP;
            r_neg   <= 1'b0;
            r_val   <= '0;
            r_ovf   <= 1'b0;
            r_args  <= '0;
            r_cur   <= '0;
            r_pay   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_stage <= n_stage;
            r_neg   <= n_neg;
            r_val   <= n_val;
            r_ovf   <= n_ovf;
            r_args  <= n_args;
            r_cur   <= n_cur;
            r_pay   <= n_pay;
        end
    end

endmodule

@@ sv/rapc_queue.sv @@
// Short first-in first-out queue of result records between the parser
// and the output stage. Depends on rapc_pkg.
module rapc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  rapc_pkg::t_rec     i_data,
    input  logic               i_rd,
    output rapc_pkg::t_rec     o_head,
    output rapc_pkg::t_qstat   o_stat
);
    import rapc_pkg::*;

    t_rec                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, n_wp;
    logic [QUEUE_AW-1:0] r_rp, n_rp;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                wr_ok, rd_ok;

    assign o_stat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;
    assign o_head       = r_mem[r_rp];

    assign wr_ok = i_wr && !o_stat.full;
    assign rd_ok = i_rd && !o_stat.empty;

    always_comb begin
        n_wp  = wr_ok ? r_wp + QUEUE_AW'(1) : r_wp;
        n_rp  = rd_ok ? r_rp + QUEUE_AW'(1) : r_rp;
        n_cnt = r_cnt + (QUEUE_AW+1)'(wr_ok) - (QUEUE_AW+1)'(rd_ok);
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ sv/rapc_back.sv @@
// Output stage: takes records from the queue, splits a two-result record
// into two words and holds the oldest result in an output register.
// Depends on rapc_pkg.
module rapc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rapc_pkg::t_rec                   i_head,
    input  logic                             i_q_empty,
    output logic                             o_q_rd,
    input  logic                             pop,
    output logic                             empty,
    output logic [2:0]                       o_event_res,
    output logic [7:0]                       o_out_byte,
    output logic [rapc_pkg::IDX_BITS-1:0]    o_arg_index,
    output logic [rapc_pkg::ALEN_BITS-1:0]   o_arg_length,
    output logic                             o_last
);
    import rapc_pkg::*;

    logic                 r_valid, n_valid;
    logic                 r_sub, n_sub;
    t_event               r_ev, n_ev;
    logic [7:0]           r_byte, n_byte;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic [ALEN_BITS-1:0] r_len, n_len;
    logic                 r_last, n_last;
    logic                 load;

    assign load   = (!r_valid || pop) && !i_q_empty;
    assign o_q_rd = load && (r_sub || !i_head.two);

    always_comb begin
        n_ev   = r_ev;
        n_byte = r_byte;
        n_idx  = r_idx;
        n_len  = r_len;
        n_last = r_last;
        n_sub  = r_sub;
        if (load) begin
            if (r_sub) begin
                n_ev   = EV_DONE;
                n_byte = '0;
                n_idx  = i_head.idx1;
                n_len  = '0;
                n_last = 1'b1;
                n_sub  = 1'b0;
            end else begin
                n_ev   = i_head.ev0;
                n_byte = i_head.byte0;
                n_idx  = i_head.idx0;
                n_len  = i_head.len0;
                n_last = !i_head.two;
                n_sub  = i_head.two;
            end
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev   <= n_ev;
        r_byte <= n_byte;
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign empty        = !r_valid;
    assign o_event_res  = r_ev;
    assign o_out_byte   = r_byte;
    assign o_arg_index  = r_idx;
    assign o_arg_length = r_len;
    assign o_last       = r_last;

endmodule

@@ sv/resp_array_command_parser_core.sv @@
// Top level of the RESP array command parser: front parser, record queue
// and output stage. Depends on rapc_pkg, rapc_front, rapc_queue, rapc_back.
//
// The block parses a request stream of the form "*<count>\r\n" followed by
// <count> bulk strings "$<len>\r\n<payload>\r\n", one byte per word on the
// input queue port. It emits one word per payload byte (event 0), an
// argument-end word carrying the declared length (event 1), a null-argument
// word for a length of -1 (event 2), a command-complete word whose index is
// the argument count (event 3), and an error word (event 4) for a bad marker,
// a bad trailer, a negative count, a length below -1 or a number that does
// not fit. Number lines are read like atoi and end only at CR directly
// followed by LF. After completion or an error the parser waits for a new
// '*'. The last flag marks the final result caused by an input byte; bytes
// that produce nothing are absorbed silently. The input side takes one byte
// every clock cycle while full is low: the parser decodes each byte
// combinationally and writes its results as one record into a four-entry
// queue. The output register delivers one result per cycle while pop is
// held, so a byte that ends the final argument (argument end plus command
// complete) yields two output words; full rises only when the queue holds
// four records. A result passes through the queue and the output register.
module resp_array_command_parser_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_in_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [2:0]                       o_event_res,
    output logic [7:0]                       o_out_byte,
    output logic [rapc_pkg::IDX_BITS-1:0]    o_arg_index,
    output logic [rapc_pkg::ALEN_BITS-1:0]   o_arg_length,
    output logic                             o_last
);
    import rapc_pkg::*;

    logic   accept;
    logic   rec_valid;
    t_rec   rec;
    t_rec   head;
    t_qstat q_stat;
    logic   q_rd;

    // A byte is taken whenever the queue has room for its record.
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    rapc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    rapc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_valid),
        .i_data  (rec),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    rapc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_empty    (q_stat.empty),
        .o_q_rd       (q_rd),
        .pop          (pop),
        .empty        (empty),
        .o_event_res  (o_event_res),
        .o_out_byte   (o_out_byte),
        .o_arg_index  (o_arg_index),
        .o_arg_length (o_arg_length),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // The queue cannot report full and empty at once.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("record queue is both full and empty");

    // Only the completion after an argument may follow another result of
    // the same byte, so a non-final result is never a completion or error.
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_event_res == EV_END || o_event_res == EV_NULL))
        else $error("non-final result is not an argument end");

    // An error is always the only result of its byte.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_res == EV_ERR) |-> o_last)
        else $error("error result not marked last");

    // The byte field is zero except on payload events.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_res != EV_BYTE) |-> (o_out_byte == 8'h00))
        else $error("byte field set on a non-payload event");
`endif

endmodule
